// ===== design/nsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg: shared types and constants of the nmea sentence framer
// Character codes, token format between the front and back halves, sentence
// kind codes and the result packing.
// ----------------------------------------------------------------------------
package nsf_pkg;

  // line store limits
  localparam int LINE_CAPACITY = 128;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LINE_LIMIT = LEN_W'(LINE_CAPACITY - 1);

  // character codes
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // positions of the bytes that are kept
  localparam logic [LEN_W-1:0] POS_TAG0  = LEN_W'(2);
  localparam logic [LEN_W-1:0] POS_TAG1  = LEN_W'(3);
  localparam logic [LEN_W-1:0] POS_TAG2  = LEN_W'(4);
  localparam logic [LEN_W-1:0] POS_FLD0  = LEN_W'(6);
  localparam logic [LEN_W-1:0] POS_FLD1  = LEN_W'(7);
  localparam logic [LEN_W-1:0] MIN_KIND_LEN  = LEN_W'(5);
  localparam logic [LEN_W-1:0] EMPTY_MIN_LEN = LEN_W'(8);

  // sentence kinds
  localparam int KIND_W = 3;
  typedef enum logic [KIND_W-1:0] {
    KIND_RMC   = 3'd0,
    KIND_GGA   = 3'd1,
    KIND_GSA   = 3'd2,
    KIND_GSV   = 3'd3,
    KIND_OTHER = 3'd4
  } kind_t;

  // three-letter tag of each known kind
  typedef logic [23:0] tag_t;
  localparam int NUM_TAGS = 4;
  localparam tag_t KIND_TAGS [NUM_TAGS] = '{"RMC", "GGA", "GSA", "GSV"};

  // token passed from the front to the back
  typedef enum logic [1:0] {
    TOK_DATA  = 2'd0,
    TOK_START = 2'd1,
    TOK_EOL   = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
  } token_t;

  // result packing on the master side
  localparam int RES_BITS = KIND_W + LEN_W + 1;
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

  // tag match: returns the kind of a three-byte tag
  function automatic kind_t tag_kind(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2);
    kind_t k;
    k = KIND_OTHER;
    for (int i = NUM_TAGS - 1; i >= 0; i--) begin
      if ({b0, b1, b2} == KIND_TAGS[i]) begin
        k = kind_t'(KIND_W'(i));
      end
    end
    return k;
  endfunction

endpackage

// ===== design/nsf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_front: byte classifier
// Sorts each received byte into start, line end or data and forms a token.
// ----------------------------------------------------------------------------
module nsf_front (
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  output logic             tok_valid,
  input  logic             tok_ready,
  output nsf_pkg::token_t  tok
);
  import nsf_pkg::*;

  // flow passes straight to the queue
  assign tok_valid = s_tvalid;
  assign s_tready  = tok_ready;

  // classify the byte
  always_comb begin
    tok.data = s_tdata;
    if (s_tdata == CH_START) begin
      tok.kind = TOK_START;
    end else if (s_tdata == CH_CR || s_tdata == CH_LF) begin
      tok.kind = TOK_EOL;
    end else begin
      tok.kind = TOK_DATA;
    end
  end

endmodule

// ===== design/nsf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_queue: two-entry token queue
// Decouples the classifier from the framer; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module nsf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  nsf_pkg::token_t  in_tok,
  output logic             out_valid,
  input  logic             out_ready,
  output nsf_pkg::token_t  out_tok
);
  import nsf_pkg::*;

  token_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_tok   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/nsf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_back: line framer
// Tracks the open line, keeps the tag and first field bytes, and registers
// one result request per completed non-empty line.
// ----------------------------------------------------------------------------
module nsf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  output logic                        tok_ready,
  input  nsf_pkg::token_t             tok,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [nsf_pkg::OUT_W-1:0]   m_tdata
);
  import nsf_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_LINE = 2'b10
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [LEN_W-1:0] stored_length;
  logic [7:0]       tag0;
  logic [7:0]       tag1;
  logic [7:0]       tag2;
  logic [7:0]       fld0;
  logic [7:0]       fld1;
  logic             step;
  logic             emit;
  kind_t            kind;
  logic             empty_flag;

  assign tok_ready = !m_tvalid || m_tready;
  assign step      = tok_valid && tok_ready;

  // line classification at line end
  always_comb begin
    kind = KIND_OTHER;
    if (stored_length > MIN_KIND_LEN) begin
      kind = tag_kind(tag0, tag1, tag2);
    end
    empty_flag = (kind != KIND_OTHER) && (stored_length >= EMPTY_MIN_LEN) &&
                 (fld0 == CH_COMMA) && (fld1 == CH_COMMA);
  end

  // phase transitions
  always_comb begin
    phase_next = phase;
    emit       = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (tok.kind == TOK_START) begin
          phase_next = PH_LINE;
        end
      end
      PH_LINE: begin
        case (tok.kind)
          TOK_EOL: begin
            phase_next = PH_IDLE;
            emit       = (stored_length != '0);
          end
          TOK_START: begin
            phase_next = PH_IDLE;
          end
          default: begin
            if (stored_length >= LINE_LIMIT) begin
              phase_next = PH_IDLE;
            end
          end
        endcase
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      stored_length <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (step) begin
        phase <= phase_next;
        if (phase == PH_IDLE) begin
          stored_length <= '0;
        end else if (tok.kind == TOK_DATA && stored_length < LINE_LIMIT) begin
          stored_length <= stored_length + LEN_W'(1);
        end
      end
      if (step && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // kept line bytes
  always_ff @(posedge clk) begin
    if (step && phase == PH_LINE && tok.kind == TOK_DATA) begin
      case (stored_length)
        POS_TAG0: tag0 <= tok.data;
        POS_TAG1: tag1 <= tok.data;
        POS_TAG2: tag2 <= tok.data;
        POS_FLD0: fld0 <= tok.data;
        POS_FLD1: fld1 <= tok.data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step && emit) begin
      m_tdata <= OUT_W'({empty_flag, stored_length, kind});
    end
  end

endmodule

// ===== design/nmea_sentence_framer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_core: nmea 0183 sentence framer
// Frames '$'-started lines from a byte stream and reports length, kind and
// empty flag of each completed line.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle, sustained, while the result side
// keeps up; a byte passes the classifier, a two-entry token queue and the
// framer step, and a result is registered in the framer once its line-ending
// byte leaves the queue. The framer takes a token whenever its result register
// is free or being read, which sets the rate. Only the bytes that decide the
// result (tag bytes 2 to 4, field bytes 6 and 7) are held; lines of more than
// 127 data bytes are dropped, as are empty lines and lines cut by a second '$'.
module nmea_sentence_framer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [2:0] sentence_kind, [9:3] line_length, [10] empty_sentence, rest zero
  output logic [nsf_pkg::OUT_W-1:0]   m_tdata
);
  import nsf_pkg::*;

  logic   f_valid;
  logic   f_ready;
  token_t f_tok;
  logic   q_valid;
  logic   q_ready;
  token_t q_tok;

  // byte classifier
  nsf_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  // token queue
  nsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_tok    (f_tok),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_tok   (q_tok)
  );

  // line framer
  nsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // a reported line is never empty
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[KIND_W +: LEN_W] != '0)
    else $error("result with zero line length");

  // short lines carry no kind
  a_short_other: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[KIND_W +: LEN_W] <= MIN_KIND_LEN)
      |-> m_tdata[KIND_W-1:0] == KIND_OTHER)
    else $error("kind reported for a short line");

  // empty flag only for known kinds of sufficient length
  a_empty_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[KIND_W + LEN_W]
      |-> (m_tdata[KIND_W-1:0] != KIND_OTHER) &&
          (m_tdata[KIND_W +: LEN_W] >= EMPTY_MIN_LEN))
    else $error("empty flag on an unknown or short line");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:RES_BITS] == '0)
    else $error("nonzero padding in result");

endmodule
